[rtl/srtf_pkg.sv]
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants of the signed radix text formatter: register
// indexes, reset values, character codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package srtf_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_RADIX    = 2'd0;
    localparam logic [1:0] CFG_SYM_LOW  = 2'd1;
    localparam logic [1:0] CFG_SYM_HIGH = 2'd2;
    localparam int         CFG_IDX_W    = 2;
    localparam int         CFG_DATA_W   = 64;

    // Register widths and reset values
    localparam int          RADIX_W         = 5;
    localparam int          SYM_W           = 8;
    localparam int          SYMS_PER_REG    = 8;
    localparam int          SYM_SLOTS       = 2 * SYMS_PER_REG;
    localparam logic [4:0]  RADIX_RESET     = 5'd10;
    localparam logic [63:0] SYM_LOW_RESET   = 64'h3736_3534_3332_3130; // "01234567"
    localparam logic [63:0] SYM_HIGH_RESET  = 64'h4645_4443_4241_3938; // "89ABCDEF"

    // Character codes
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] PRINT_LO  = 8'd32;
    localparam logic [7:0] PRINT_HI  = 8'd126;
    localparam logic [7:0] CHAR_NONE = 8'h00;

    // Quotient bits retired per divider cycle
    localparam int DIV_BITS = 8;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SIGN = 5'b00100,
        S_EMIT = 5'b01000,
        S_ERR  = 5'b10000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture sign and magnitude of the accepted value
        logic div_step;    // run one divider cycle
        logic emit_sign;   // load '-' into the output register
        logic emit_digit;  // load the top digit symbol and pop it
        logic emit_err;    // load the error transaction
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic bad;         // alphabet is invalid
        logic neg;         // captured value was negative
        logic div_last;    // this divider cycle finishes a digit
        logic div_done;    // next quotient is zero or this digit fills the stack
        logic last_digit;  // one digit left on the stack
        logic out_free;    // output register can take a new transaction
    } t_stat;

endpackage

[rtl/signed_radix_text_formatter.sv]
// ----------------------------------------------------------------------------
// signed_radix_text_formatter
// Formats a signed integer as text in a configurable radix and alphabet.
// ----------------------------------------------------------------------------
// One value is taken at a time. After acceptance the divider produces the
// digits, least significant digit first, onto a digit stack (it retires 8
// quotient bits a cycle); then '-' (for negative values) and the digits go
// out most significant first, one character per cycle while the consumer is
// ready. The input is ready again once the last character sits in the
// output register. An invalid alphabet gives a single transaction with
// alphabet_bad and last set and character zero. Configuration writes are
// taken in every cycle out of reset and must only be issued while no value
// is in progress.
// ----------------------------------------------------------------------------
module signed_radix_text_formatter #(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srtf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srtf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [VALUE_BITS-1:0]    i_value,
    // Output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [srtf_pkg::SYM_W-1:0]      o_character,
    output logic                            o_last,
    output logic                            o_alphabet_bad
);

    srtf_pkg::t_cmd  cmd;
    srtf_pkg::t_stat stat;

    // Refuse writes while reset is held
    assign o_cfg_ready = i_rst_n;

    // Sequencer
    srtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath
    srtf_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_value        (i_value),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_character    (o_character),
        .o_last         (o_last),
        .o_alphabet_bad (o_alphabet_bad)
    );

endmodule

[rtl/srtf_ctrl.sv]
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer of the formatter: accepts a value, runs the digit divider, then
// emits the sign and the digits one transaction at a time.
// ----------------------------------------------------------------------------
module srtf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  srtf_pkg::t_stat i_stat,
    output srtf_pkg::t_cmd  o_cmd
);

    srtf_pkg::t_state r_state;
    srtf_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srtf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            srtf_pkg::S_IDLE: begin
                // Take nothing while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.bad ? srtf_pkg::S_ERR : srtf_pkg::S_DIV;
                end
            end
            srtf_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last && i_stat.div_done) begin
                    n_state = i_stat.neg ? srtf_pkg::S_SIGN : srtf_pkg::S_EMIT;
                end
            end
            srtf_pkg::S_SIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = srtf_pkg::S_EMIT;
                end
            end
            srtf_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_stat.last_digit) begin
                        n_state = srtf_pkg::S_IDLE;
                    end
                end
            end
            srtf_pkg::S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = srtf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srtf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/srtf_dp.sv]
// ----------------------------------------------------------------------------
// srtf_dp
// Datapath of the formatter: configuration registers, alphabet check,
// radix divider, digit stack and output register.
// ----------------------------------------------------------------------------
module srtf_dp #(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [srtf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [srtf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [VALUE_BITS-1:0]        i_value,
    input  srtf_pkg::t_cmd                      i_cmd,
    output srtf_pkg::t_stat                     o_stat,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [srtf_pkg::SYM_W-1:0]          o_character,
    output logic                                o_last,
    output logic                                o_alphabet_bad
);

    localparam int DIGIT_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int REM_W   = DIGIT_W + 1;
    localparam int PASSES  = (VALUE_BITS + srtf_pkg::DIV_BITS - 1) / srtf_pkg::DIV_BITS;
    localparam int QUOT_W  = PASSES * srtf_pkg::DIV_BITS;
    localparam int PASS_W  = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int DEPTH   = VALUE_BITS + 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Configuration registers
    logic [srtf_pkg::RADIX_W-1:0] r_radix;
    logic [63:0]                  r_sym_low;
    logic [63:0]                  r_sym_high;

    // Divider and digit stack
    logic [QUOT_W-1:0]  r_quot;
    logic [REM_W-1:0]   r_rem;
    logic [PASS_W-1:0]  r_pass;
    logic [CNT_W-1:0]   r_count;
    logic               r_neg;
    logic [DIGIT_W-1:0] r_stack [DEPTH];

    logic [QUOT_W-1:0]  n_quot;
    logic [REM_W-1:0]   n_rem;

    // Output register
    logic                       r_out_valid;
    logic [srtf_pkg::SYM_W-1:0] r_character;
    logic                       r_last;
    logic                       r_bad;

    logic [srtf_pkg::SYM_W-1:0] sym [srtf_pkg::SYM_SLOTS];
    logic                       alpha_bad;
    logic [VALUE_BITS-1:0]      v_u;
    logic [VALUE_BITS-1:0]      mag;
    logic [REM_W-1:0]           radix_d;
    logic                       out_free;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= srtf_pkg::RADIX_RESET;
            r_sym_low  <= srtf_pkg::SYM_LOW_RESET;
            r_sym_high <= srtf_pkg::SYM_HIGH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                srtf_pkg::CFG_RADIX:    r_radix    <= i_cfg_data[srtf_pkg::RADIX_W-1:0];
                srtf_pkg::CFG_SYM_LOW:  r_sym_low  <= i_cfg_data;
                srtf_pkg::CFG_SYM_HIGH: r_sym_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack symbol bytes
    always_comb begin
        for (int k = 0; k < srtf_pkg::SYMS_PER_REG; k++) begin
            sym[k]                         = r_sym_low[k*srtf_pkg::SYM_W +: srtf_pkg::SYM_W];
            sym[k + srtf_pkg::SYMS_PER_REG] = r_sym_high[k*srtf_pkg::SYM_W +: srtf_pkg::SYM_W];
        end
    end

    // Check the alphabet in use: radix range, forbidden symbols, repeats
    always_comb begin
        alpha_bad = (r_radix < srtf_pkg::RADIX_W'(2)) ||
                    (r_radix > srtf_pkg::RADIX_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (srtf_pkg::RADIX_W'(i) < r_radix) begin
                if (sym[i] == srtf_pkg::SYM_PLUS || sym[i] == srtf_pkg::SYM_MINUS ||
                    sym[i] < srtf_pkg::PRINT_LO || sym[i] > srtf_pkg::PRINT_HI) begin
                    alpha_bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if (srtf_pkg::RADIX_W'(j) < r_radix && sym[i] == sym[j]) begin
                        alpha_bad = 1'b1;
                    end
                end
            end
        end
    end

    // Magnitude of the incoming value
    assign v_u     = $unsigned(i_value);
    assign mag     = v_u[VALUE_BITS-1] ? (~v_u + 1'b1) : v_u;
    assign radix_d = r_radix[REM_W-1:0];

    // One divider cycle: retire DIV_BITS quotient bits, restoring style
    always_comb begin
        logic [REM_W-1:0]  rem_t;
        logic [QUOT_W-1:0] q_t;
        rem_t = r_rem;
        q_t   = r_quot;
        for (int k = 0; k < srtf_pkg::DIV_BITS; k++) begin
            rem_t = {rem_t[DIGIT_W-1:0], q_t[QUOT_W-1]};
            q_t   = {q_t[QUOT_W-2:0], 1'b0};
            if (rem_t >= radix_d) begin
                rem_t  = rem_t - radix_d;
                q_t[0] = 1'b1;
            end
        end
        n_rem  = rem_t;
        n_quot = q_t;
    end

    // Divider control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass  <= '0;
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_pass  <= '0;
            r_count <= '0;
        end else if (i_cmd.div_step) begin
            if (o_stat.div_last) begin
                r_pass  <= '0;
                r_count <= r_count + 1'b1;
            end else begin
                r_pass  <= r_pass + 1'b1;
            end
        end else if (i_cmd.emit_digit) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Divider data and digit stack: push on digit done, pop on emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot <= QUOT_W'(mag);
            r_rem  <= '0;
            r_neg  <= v_u[VALUE_BITS-1];
        end else if (i_cmd.div_step) begin
            r_quot <= n_quot;
            if (o_stat.div_last) begin
                r_rem <= '0;
                for (int k = DEPTH - 1; k > 0; k--) begin
                    r_stack[k] <= r_stack[k-1];
                end
                r_stack[0] <= n_rem[DIGIT_W-1:0];
            end else begin
                r_rem <= n_rem;
            end
        end else if (i_cmd.emit_digit) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                r_stack[k] <= r_stack[k+1];
            end
        end
    end

    // Output register valid: set on any emit command, drop when taken
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_character <= srtf_pkg::SYM_MINUS;
            r_last      <= 1'b0;
            r_bad       <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_character <= sym[4'(r_stack[0])];
            r_last      <= o_stat.last_digit;
            r_bad       <= 1'b0;
        end else if (i_cmd.emit_err) begin
            r_character <= srtf_pkg::CHAR_NONE;
            r_last      <= 1'b1;
            r_bad       <= 1'b1;
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.bad        = alpha_bad;
        o_stat.neg        = r_neg;
        o_stat.div_last   = (r_pass == PASS_W'(PASSES - 1));
        o_stat.div_done   = (n_quot == '0) || (r_count == CNT_W'(VALUE_BITS));
        o_stat.last_digit = (r_count == CNT_W'(1));
        o_stat.out_free   = out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_character    = r_character;
    assign o_last         = r_last;
    assign o_alphabet_bad = r_bad;

endmodule

[rtl/srtf_chk.sv]
// ----------------------------------------------------------------------------
// srtf_chk
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module srtf_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [srtf_pkg::SYM_W-1:0] o_character,
    input logic                       o_last,
    input logic                       o_alphabet_bad
);

    // Hold a pending output transaction until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // An error transaction stands alone with no text
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_alphabet_bad |-> o_last && o_character == srtf_pkg::CHAR_NONE)
        else $error("error transaction malformed");

    // Text characters are printable and never '+'
    a_char_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_alphabet_bad |->
            o_character >= srtf_pkg::PRINT_LO && o_character <= srtf_pkg::PRINT_HI &&
            o_character != srtf_pkg::SYM_PLUS)
        else $error("emitted character outside alphabet range");

    // An accepted value keeps the input busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted value");

endmodule

bind signed_radix_text_formatter srtf_chk u_srtf_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_character    (o_character),
    .o_last         (o_last),
    .o_alphabet_bad (o_alphabet_bad)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for signed_radix_text_formatter. A short table of
// directed rows covers the reset alphabet, extreme values, radix 2 and 16,
// and every kind of broken alphabet. Random phases follow, each with its own
// radix and alphabet. Expected characters come from the literal text of a
// table row or from a local model of the formatter and are compared field by
// field in arrival order, with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;

    localparam int              MAX_SYMBOLS   = 16;
    localparam int              VALUE_BITS    = 32;
    localparam logic [1:0]      CFG_SPARE     = 2'd3;   // decodes to no register
    localparam int              STALL_LIMIT   = 4000;
    localparam int              SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [srtf_pkg::SYM_W-1:0] ch;
        logic                       last;
        logic                       bad;
    } t_text_beat;

    typedef enum {ROW_CFG, ROW_FMT, ROW_TXT, ROW_ERR, ROW_DRAIN} t_plan_kind;
    typedef enum {FAULT_NONE, FAULT_DUP, FAULT_PLUS, FAULT_MINUS, FAULT_LOW,
                  FAULT_HIGH} t_fault;

    typedef struct {
        t_plan_kind                           kind;
        logic [srtf_pkg::CFG_IDX_W-1:0]       idx;
        logic [srtf_pkg::CFG_DATA_W-1:0]      data;
        logic signed [VALUE_BITS-1:0]         value;
        string                                text;
    } t_plan_row;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [srtf_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [srtf_pkg::CFG_DATA_W-1:0]      i_cfg_data;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic signed [VALUE_BITS-1:0]         i_value;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic [srtf_pkg::SYM_W-1:0]           o_character;
    logic                                 o_last;
    logic                                 o_alphabet_bad;

    // Local copy of the configuration registers
    logic [srtf_pkg::RADIX_W-1:0]         radix_q;
    logic [63:0]                          syms_low_q;
    logic [63:0]                          syms_high_q;

    t_text_beat                           pending_text[$];
    t_plan_row                            plan[$];
    int                                   error_count = 0;
    int                                   idle_cycles = 0;
    bit                                   cfg_open = 1'b0;
    bit                                   calm = 1'b0;

    signed_radix_text_formatter #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .VALUE_BITS  (VALUE_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_character    (o_character),
        .o_last         (o_last),
        .o_alphabet_bad (o_alphabet_bad)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_error(input string what);
        error_count++;
        $display("tb: mismatch %0d: %s", error_count, what);
    endtask

    // Mostly back to back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [srtf_pkg::SYM_W-1:0] glyph(input int idx);
        logic [127:0] both;
        both = {syms_high_q, syms_low_q};
        return both[idx*srtf_pkg::SYM_W +: srtf_pkg::SYM_W];
    endfunction

    // Expected text of one value under the current radix and alphabet
    function automatic void format_value(input logic signed [VALUE_BITS-1:0] v);
        logic                       bad;
        logic [srtf_pkg::SYM_W-1:0] s;
        logic [31:0]                raw;
        logic [31:0]                mag;
        logic [31:0]                base;
        int                         digits[0:VALUE_BITS];
        int                         nd;
        bad = (radix_q < 2) || (radix_q > MAX_SYMBOLS);
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (!bad && i < radix_q) begin
                s = glyph(i);
                if (s == srtf_pkg::SYM_PLUS || s == srtf_pkg::SYM_MINUS ||
                    s < srtf_pkg::PRINT_LO || s > srtf_pkg::PRINT_HI) begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < radix_q; j++) begin
                    if (glyph(j) == s) begin
                        bad = 1'b1;
                    end
                end
            end
        end
        if (bad) begin
            pending_text.push_back('{ch: srtf_pkg::CHAR_NONE, last: 1'b1, bad: 1'b1});
            return;
        end
        raw  = v;
        mag  = raw[31] ? (~raw + 32'd1) : raw;
        base = {27'd0, radix_q};
        nd   = 0;
        do begin
            digits[nd] = int'(mag % base);
            mag = mag / base;
            nd++;
        end while (mag != 0);
        if (raw[31]) begin
            pending_text.push_back('{ch: srtf_pkg::SYM_MINUS, last: 1'b0, bad: 1'b0});
        end
        for (int i = nd - 1; i >= 0; i--) begin
            pending_text.push_back('{ch: glyph(digits[i]), last: (i == 0), bad: 1'b0});
        end
    endfunction

    // Drop input valid and close the config channel, then hold until drained
    task automatic go_idle();
        i_in_valid <= 1'b0;
        if (cfg_open) begin
            i_cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        do @(posedge i_clk); while (pending_text.size() != 0 || o_in_ready !== 1'b1);
    endtask

    // Issue one register write and track it locally once accepted
    task automatic write_reg(input logic [srtf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        cfg_open = 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            srtf_pkg::CFG_RADIX:    radix_q     = data[srtf_pkg::RADIX_W-1:0];
            srtf_pkg::CFG_SYM_LOW:  syms_low_q  = data;
            srtf_pkg::CFG_SYM_HIGH: syms_high_q = data;
            default: ;
        endcase
    endtask

    // Present one value after a random gap and return at its acceptance
    task automatic offer_value(input logic signed [VALUE_BITS-1:0] v);
        int gap;
        gap = pick_gap();
        if (cfg_open) begin
            i_cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    // Consumer: ready with occasional stalls of random length
    initial begin
        int hold;
        hold = 0;
        forever begin
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
                hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
            @(posedge i_clk);
        end
    end

    // Compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_text_beat want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_text.size() == 0) begin
                flag_error($sformatf("unexpected character 8'h%02h", o_character));
            end else begin
                want = pending_text.pop_front();
                if (o_character !== want.ch) begin
                    flag_error($sformatf("character 8'h%02h, want 8'h%02h",
                                         o_character, want.ch));
                end
                if (o_last !== want.last) begin
                    flag_error($sformatf("last %b, want %b", o_last, want.last));
                end
                if (o_alphabet_bad !== want.bad) begin
                    flag_error($sformatf("alphabet_bad %b, want %b", o_alphabet_bad, want.bad));
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial begin
        int                         rad;
        int                         items;
        int                         sel;
        int                         k;
        int                         slot;
        t_fault                     fault;
        logic [127:0]               syms;
        logic [srtf_pkg::SYM_W-1:0] c;
        bit                         taken[256];
        logic [31:0]                v;
        logic [31:0]                base;
        logic [63:0]                rdata;

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= srtf_pkg::CFG_RADIX;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_value     <= '0;
        radix_q     = srtf_pkg::RADIX_RESET;
        syms_low_q  = srtf_pkg::SYM_LOW_RESET;
        syms_high_q = srtf_pkg::SYM_HIGH_RESET;

        // Reset alphabet, extremes, radix 2 and 16, then each broken alphabet
        plan.push_back('{ROW_TXT, srtf_pkg::CFG_RADIX, 64'd0, 32'sd0, "0"});
        plan.push_back('{ROW_TXT, srtf_pkg::CFG_RADIX, 64'd0, -32'sd1, "-1"});
        plan.push_back('{ROW_TXT, srtf_pkg::CFG_RADIX, 64'd0, 32'sh7FFF_FFFF, "2147483647"});
        plan.push_back('{ROW_TXT, srtf_pkg::CFG_RADIX, 64'd0, 32'sh8000_0000, "-2147483648"});
        plan.push_back('{ROW_DRAIN, srtf_pkg::CFG_RADIX, 64'd0, 32'sd0, ""});
        plan.push_back('{ROW_FMT, srtf_pkg::CFG_RADIX, 64'd0, 32'sd123456789, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_RADIX, 64'hFFFF_FFFF_FFFF_FFE2, 32'sd0, ""});
        plan.push_back('{ROW_FMT, srtf_pkg::CFG_RADIX, 64'd0, 32'sh8000_0000, ""});
        plan.push_back('{ROW_FMT, srtf_pkg::CFG_RADIX, 64'd0, 32'sh7FFF_FFFF, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_RADIX, 64'd16, 32'sd0, ""});
        plan.push_back('{ROW_TXT, srtf_pkg::CFG_RADIX, 64'd0, 32'sh8000_0000, "-80000000"});
        plan.push_back('{ROW_TXT, srtf_pkg::CFG_RADIX, 64'd0, 32'sh7FFF_FFFF, "7FFFFFFF"});
        plan.push_back('{ROW_TXT, srtf_pkg::CFG_RADIX, 64'd0, -32'sd1, "-1"});
        plan.push_back('{ROW_TXT, srtf_pkg::CFG_RADIX, 64'd0, 32'sd255, "FF"});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_RADIX, 64'h20, 32'sd0, ""});
        plan.push_back('{ROW_ERR, srtf_pkg::CFG_RADIX, 64'd0, 32'sd5, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_RADIX, 64'd1, 32'sd0, ""});
        plan.push_back('{ROW_ERR, srtf_pkg::CFG_RADIX, 64'd0, -32'sd7, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_RADIX, 64'd17, 32'sd0, ""});
        plan.push_back('{ROW_ERR, srtf_pkg::CFG_RADIX, 64'd0, 32'sd0, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_RADIX, 64'h1F, 32'sd0, ""});
        plan.push_back('{ROW_ERR, srtf_pkg::CFG_RADIX, 64'd0, 32'sh8000_0000, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_RADIX, 64'd10, 32'sd0, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_SYM_LOW, 64'h3736_3534_2B32_3130, 32'sd0, ""});
        plan.push_back('{ROW_ERR, srtf_pkg::CFG_RADIX, 64'd0, 32'sd42, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_SYM_LOW, 64'h3736_3534_3332_312D, 32'sd0, ""});
        plan.push_back('{ROW_ERR, srtf_pkg::CFG_RADIX, 64'd0, 32'sd42, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_SYM_LOW, 64'h1F36_3534_3332_3130, 32'sd0, ""});
        plan.push_back('{ROW_ERR, srtf_pkg::CFG_RADIX, 64'd0, 32'sd42, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_SYM_LOW, 64'h7F36_3534_3332_3130, 32'sd0, ""});
        plan.push_back('{ROW_ERR, srtf_pkg::CFG_RADIX, 64'd0, 32'sd42, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_SYM_LOW, srtf_pkg::SYM_LOW_RESET, 32'sd0, ""});
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_SYM_HIGH, 64'h4645_4443_4241_3038, 32'sd0,
                         ""});
        plan.push_back('{ROW_ERR, srtf_pkg::CFG_RADIX, 64'd0, 32'sd42, ""});
        // Duplicate now sits past the radix
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_RADIX, 64'd9, 32'sd0, ""});
        plan.push_back('{ROW_FMT, srtf_pkg::CFG_RADIX, 64'd0, 32'sd999, ""});
        plan.push_back('{ROW_CFG, CFG_SPARE, 64'd1, 32'sd0, ""});
        plan.push_back('{ROW_FMT, srtf_pkg::CFG_RADIX, 64'd0, -32'sd255, ""});
        // Space and tilde are the printable bounds
        plan.push_back('{ROW_CFG, srtf_pkg::CFG_SYM_LOW, 64'h3736_3534_3332_7E20, 32'sd0, ""});
        plan.push_back('{ROW_TXT, srtf_pkg::CFG_RADIX, 64'd0, 32'sd0, " "});
        plan.push_back('{ROW_FMT, srtf_pkg::CFG_RADIX, 64'd0, -32'sd80, ""});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[r]) begin
            case (plan[r].kind)
                ROW_CFG: begin
                    go_idle();
                    write_reg(plan[r].idx, plan[r].data);
                end
                ROW_DRAIN: begin
                    go_idle();
                end
                ROW_FMT: begin
                    offer_value(plan[r].value);
                    format_value(plan[r].value);
                end
                ROW_TXT: begin
                    offer_value(plan[r].value);
                    for (int n = 0; n < plan[r].text.len(); n++) begin
                        pending_text.push_back('{ch: plan[r].text[n],
                                                 last: (n == plan[r].text.len() - 1),
                                                 bad: 1'b0});
                    end
                end
                default: begin
                    offer_value(plan[r].value);
                    pending_text.push_back('{ch: srtf_pkg::CHAR_NONE, last: 1'b1,
                                             bad: 1'b1});
                end
            endcase
        end

        // Random phases, each with its own radix and alphabet
        for (int p = 0; p < 8; p++) begin
            fault = FAULT_NONE;
            case (p)
                0: rad = 2;
                1: rad = MAX_SYMBOLS;
                3: rad = 10;
                5: rad = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
                default: rad = $urandom_range(2, MAX_SYMBOLS);
            endcase
            if (p == 6) begin
                fault = t_fault'($urandom_range(FAULT_DUP, FAULT_HIGH));
            end
            calm = (p == 3);

            // Draw distinct legal symbols; slots past the radix may hold junk
            taken = '{default: 1'b0};
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                if (i >= rad && $urandom_range(0, 3) == 0) begin
                    c = srtf_pkg::SYM_W'($urandom_range(0, 255));
                end else begin
                    do c = srtf_pkg::SYM_W'($urandom_range(srtf_pkg::PRINT_LO,
                                                           srtf_pkg::PRINT_HI));
                    while (c == srtf_pkg::SYM_PLUS || c == srtf_pkg::SYM_MINUS || taken[c]);
                    taken[c] = 1'b1;
                end
                syms[i*srtf_pkg::SYM_W +: srtf_pkg::SYM_W] = c;
            end

            // Break one symbol within the radix
            if (fault != FAULT_NONE) begin
                slot = $urandom_range(0, rad - 1);
                case (fault)
                    FAULT_DUP:
                        syms[slot*srtf_pkg::SYM_W +: srtf_pkg::SYM_W] =
                            syms[((slot + 1) % rad)*srtf_pkg::SYM_W +: srtf_pkg::SYM_W];
                    FAULT_PLUS:
                        syms[slot*srtf_pkg::SYM_W +: srtf_pkg::SYM_W] = srtf_pkg::SYM_PLUS;
                    FAULT_MINUS:
                        syms[slot*srtf_pkg::SYM_W +: srtf_pkg::SYM_W] = srtf_pkg::SYM_MINUS;
                    FAULT_LOW:
                        syms[slot*srtf_pkg::SYM_W +: srtf_pkg::SYM_W] =
                            srtf_pkg::SYM_W'($urandom_range(0, srtf_pkg::PRINT_LO - 1));
                    default:
                        syms[slot*srtf_pkg::SYM_W +: srtf_pkg::SYM_W] =
                            srtf_pkg::SYM_W'($urandom_range(srtf_pkg::PRINT_HI + 1, 255));
                endcase
            end

            rdata = {$urandom, $urandom};
            rdata[srtf_pkg::RADIX_W-1:0] = srtf_pkg::RADIX_W'(rad);
            go_idle();
            write_reg(srtf_pkg::CFG_RADIX, rdata);
            write_reg(srtf_pkg::CFG_SYM_LOW, syms[63:0]);
            write_reg(srtf_pkg::CFG_SYM_HIGH, syms[127:64]);

            items = (p == 5 || p == 6) ? 10 : 25;
            base  = (rad >= 2 && rad <= MAX_SYMBOLS) ? rad : 10;
            repeat (items) begin
                // Now and then hold the sender until every result is in
                if ($urandom_range(0, 19) == 0) begin
                    go_idle();
                end
                sel = $urandom_range(0, 9);
                case (sel)
                    0, 1, 2, 3: v = $urandom;
                    4, 5: v = $urandom_range(0, 300);
                    6: begin
                        case ($urandom_range(0, 3))
                            0: v = '0;
                            1: v = 32'd1;
                            2: v = 32'h7FFF_FFFF;
                            default: v = 32'h8000_0000;
                        endcase
                    end
                    7: begin
                        // Land next to a power of the radix
                        v = 32'd1;
                        k = $urandom_range(1, 31);
                        repeat (k) begin
                            if (v <= 32'h7FFF_FFFF / base) begin
                                v = v * base;
                            end
                        end
                        v = v + $urandom_range(0, 2) - 32'd1;
                    end
                    default: v = $urandom >> $urandom_range(0, 31);
                endcase
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
                offer_value($signed(v));
                format_value($signed(v));
            end
        end

        go_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
